[rtl/iqagc_pkg.sv]
// Shared types and constants for the I/Q automatic gain control.
// Used by iqagc_ctrl, iqagc_dp and the iq_agc_asymmetric top level.
package iqagc_pkg;

  // Field widths
  localparam int unsigned SmpW  = 16;  // Q1.15 samples
  localparam int unsigned GainW = 24;  // unsigned Q8.16 gain
  localparam int unsigned PwrW  = 32;  // unsigned Q2.30 power / reference
  localparam int unsigned RateW = 16;  // unsigned Q0.16 rates
  localparam int unsigned CfgIdxW = 2;

  // Shared multiplier operand widths
  localparam int unsigned MulAW = 18;
  localparam int unsigned MulBW = 25;
  localparam int unsigned ProdW = MulAW + MulBW;

  // Reset values
  localparam logic [GainW-1:0] GAIN_RESET = 24'd3276800;    // 50.0
  localparam logic [PwrW-1:0]  REF_RESET  = 32'd1073741824; // 1.0
  localparam logic [RateW-1:0] SLOW_RESET = 16'd131;        // ~0.002
  localparam logic [RateW-1:0] FAST_RESET = 16'd3277;       // ~0.050

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_REF_POWER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RATE_SLOW = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RATE_FAST = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE_I,
    ST_SCALE_Q,
    ST_SQR_I,
    ST_SQR_Q,
    ST_ERR,
    ST_PROD_LO,
    ST_PROD_HI,
    ST_UPDATE,
    ST_PUSH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SCALE_I,
    OP_SCALE_Q,
    OP_SQR_I,
    OP_SQR_Q,
    OP_ERR,
    OP_PROD_LO,
    OP_PROD_HI,
    OP_UPDATE
  } op_e;

  // Sequencer to datapath control
  typedef struct packed {
    op_e  op;
    logic load;  // capture a new input item
    logic push;  // hand results to the output register
  } ctrl_t;

endpackage

[rtl/iq_agc_asymmetric.sv]
// Each input item makes six passes through one shared 18x25 multiplier plus
// error and gain-update steps; the result is pushed to the output register from
// the update step, or later from a push state once the full output register frees.
// Input is not accepted while an item is in the sequencer; a finished result
// waits in the output register while the next item is taken.
// Reset (rst_ni low, async): sequencer idle, output empty, gain 50.0,
// ref_power 1.0, rate_slow 131, rate_fast 3277.
module iq_agc_asymmetric (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input items
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [31:0]                        s_axis_tdata_i,  // in_i[15:0], in_q[31:16]
  // result items
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [31:0]                        m_axis_tdata_o,  // out_i[15:0], out_q[31:16]
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [iqagc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);
  import iqagc_pkg::*;

  logic [PwrW-1:0]        ref_power_q;
  logic [RateW-1:0]       rate_slow_q, rate_fast_q;
  logic                   m_valid_q;
  logic [31:0]            m_data_q;
  logic                   out_free;
  ctrl_t                  ctrl;
  logic signed [SmpW-1:0] res_i, res_q;

  // Configuration: always ready, unknown indexes dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_power_q <= REF_RESET;
      rate_slow_q <= SLOW_RESET;
      rate_fast_q <= FAST_RESET;
    end else if (cfg_valid_i) begin
      priority if (cfg_index_i == CFG_REF_POWER) begin
        ref_power_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_RATE_SLOW) begin
        rate_slow_q <= cfg_data_i[RateW-1:0];
      end else if (cfg_index_i == CFG_RATE_FAST) begin
        rate_fast_q <= cfg_data_i[RateW-1:0];
      end else begin
      end
    end
  end

  // Output register is free when empty or being drained this cycle
  assign out_free = !m_valid_q || m_axis_tready_i;

  iqagc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .out_free_i (out_free),
    .ready_o    (s_axis_tready_o),
    .ctrl_o     (ctrl)
  );

  iqagc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_i_i      (s_axis_tdata_i[15:0]),
    .in_q_i      (s_axis_tdata_i[31:16]),
    .ref_power_i (ref_power_q),
    .rate_slow_i (rate_slow_q),
    .rate_fast_i (rate_fast_q),
    .out_i_o     (res_i),
    .out_q_o     (res_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.push) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_data_q <= '0;
    end else if (ctrl.push) begin
      m_data_q <= {res_q, res_i};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Sequencer goes busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input still ready after accepting an item");

  // A new result appears only after a push from the sequencer
  a_valid_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(ctrl.push))
    else $error("output valid without a push");

  // Result data only changes on a push
  a_data_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(ctrl.push) |-> $stable(m_axis_tdata_o))
    else $error("output data changed without a push");

  // Never push while the sequencer is idle
  a_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |-> !s_axis_tready_o)
    else $error("push while idle");

endmodule

[rtl/iqagc_ctrl.sv]
// Sequencer for the I/Q gain control: steps the shared multiplier
// through one item. Depends on iqagc_pkg.
module iqagc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  input  logic               out_free_i,
  output logic               ready_o,
  output iqagc_pkg::ctrl_t   ctrl_o
);
  import iqagc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (s_valid_i) state_d = ST_SCALE_I;
      ST_SCALE_I: state_d = ST_SCALE_Q;
      ST_SCALE_Q: state_d = ST_SQR_I;
      ST_SQR_I:   state_d = ST_SQR_Q;
      ST_SQR_Q:   state_d = ST_ERR;
      ST_ERR:     state_d = ST_PROD_LO;
      ST_PROD_LO: state_d = ST_PROD_HI;
      ST_PROD_HI: state_d = ST_UPDATE;
      ST_UPDATE:  state_d = out_free_i ? ST_IDLE : ST_PUSH;
      ST_PUSH:    if (out_free_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ready_o     = 1'b0;
    ctrl_o.op   = OP_NONE;
    ctrl_o.load = 1'b0;
    ctrl_o.push = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        ready_o     = 1'b1;
        ctrl_o.load = s_valid_i;
      end
      ST_SCALE_I: ctrl_o.op = OP_SCALE_I;
      ST_SCALE_Q: ctrl_o.op = OP_SCALE_Q;
      ST_SQR_I:   ctrl_o.op = OP_SQR_I;
      ST_SQR_Q:   ctrl_o.op = OP_SQR_Q;
      ST_ERR:     ctrl_o.op = OP_ERR;
      ST_PROD_LO: ctrl_o.op = OP_PROD_LO;
      ST_PROD_HI: ctrl_o.op = OP_PROD_HI;
      ST_UPDATE: begin
        ctrl_o.op   = OP_UPDATE;
        ctrl_o.push = out_free_i;
      end
      ST_PUSH:    ctrl_o.push = out_free_i;
      default:    ctrl_o.op = OP_NONE;
    endcase
  end

endmodule

[rtl/iqagc_dp.sv]
// Datapath for the I/Q gain control: one shared 18x25 signed multiplier,
// rounding/saturation, power and error, gain register. Depends on iqagc_pkg.
module iqagc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  iqagc_pkg::ctrl_t                    ctrl_i,
  input  logic signed [iqagc_pkg::SmpW-1:0]   in_i_i,
  input  logic signed [iqagc_pkg::SmpW-1:0]   in_q_i,
  input  logic [iqagc_pkg::PwrW-1:0]          ref_power_i,
  input  logic [iqagc_pkg::RateW-1:0]         rate_slow_i,
  input  logic [iqagc_pkg::RateW-1:0]         rate_fast_i,
  output logic signed [iqagc_pkg::SmpW-1:0]   out_i_o,
  output logic signed [iqagc_pkg::SmpW-1:0]   out_q_o
);
  import iqagc_pkg::*;

  localparam int unsigned ErrW = PwrW + 2;
  localparam int unsigned AccW = 51;
  localparam int unsigned DeltaW = AccW - 30;
  localparam int unsigned GSumW = GainW + 2;

  logic signed [SmpW-1:0]  smp_i_q, smp_q_q;
  logic signed [SmpW-1:0]  res_i_q, res_q_q;
  logic [PwrW-1:0]         pwr_q;
  logic signed [ErrW-1:0]  err_q;
  logic signed [AccW-1:0]  acc_q;
  logic [GainW-1:0]        gain_q, gain_d;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod, prod_rnd, prod_shr;
  logic signed [SmpW-1:0]  scaled;
  logic signed [AccW-1:0]  prod_ext, acc_rnd;
  logic signed [DeltaW-1:0] delta;
  logic signed [GSumW-1:0] gsum;
  logic signed [ErrW-1:0]  err_d;
  logic [RateW-1:0]        rate_sel;

  // Error > 0 means power below target: adapt slowly
  assign rate_sel = (err_q > 0) ? rate_slow_i : rate_fast_i;

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl_i.op)
      OP_SCALE_I: begin
        mul_a = {{(MulAW-SmpW){smp_i_q[SmpW-1]}}, smp_i_q};
        mul_b = {1'b0, gain_q};
      end
      OP_SCALE_Q: begin
        mul_a = {{(MulAW-SmpW){smp_q_q[SmpW-1]}}, smp_q_q};
        mul_b = {1'b0, gain_q};
      end
      OP_SQR_I: begin
        mul_a = {{(MulAW-SmpW){res_i_q[SmpW-1]}}, res_i_q};
        mul_b = {{(MulBW-SmpW){res_i_q[SmpW-1]}}, res_i_q};
      end
      OP_SQR_Q: begin
        mul_a = {{(MulAW-SmpW){res_q_q[SmpW-1]}}, res_q_q};
        mul_b = {{(MulBW-SmpW){res_q_q[SmpW-1]}}, res_q_q};
      end
      // error split into unsigned low 17 bits and signed high 17 bits
      OP_PROD_LO: begin
        mul_a = {1'b0, err_q[16:0]};
        mul_b = {{(MulBW-RateW){1'b0}}, rate_sel};
      end
      OP_PROD_HI: begin
        mul_a = {err_q[ErrW-1], err_q[ErrW-1:17]};
        mul_b = {{(MulBW-RateW){1'b0}}, rate_sel};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Round half up by 2^16, then saturate to Q1.15
  assign prod_rnd = prod + ProdW'(32768);
  assign prod_shr = prod_rnd >>> 16;
  always_comb begin
    if (prod_shr > ProdW'(32767)) begin
      scaled = 16'sh7FFF;
    end else if (prod_shr < -ProdW'(32768)) begin
      scaled = -16'sh8000;
    end else begin
      scaled = prod_shr[SmpW-1:0];
    end
  end

  assign err_d    = $signed({2'b00, ref_power_i}) - $signed({2'b00, pwr_q});
  assign prod_ext = {{(AccW-ProdW){prod[ProdW-1]}}, prod};

  // Gain update: round(d / 2^30) added to gain, clamped to 24 bits
  assign acc_rnd = acc_q + AccW'(32'h2000_0000);
  assign delta   = DeltaW'(acc_rnd >>> 30);
  assign gsum    = $signed({2'b00, gain_q})
                 + {{(GSumW-DeltaW){delta[DeltaW-1]}}, delta};
  always_comb begin
    if (gsum < 0) begin
      gain_d = '0;
    end else if (gsum > $signed({2'b00, {GainW{1'b1}}})) begin
      gain_d = '1;
    end else begin
      gain_d = gsum[GainW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (ctrl_i.op == OP_UPDATE) begin
      gain_q <= gain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      smp_i_q <= in_i_i;
      smp_q_q <= in_q_i;
    end
    unique case (ctrl_i.op)
      OP_SCALE_I: res_i_q <= scaled;
      OP_SCALE_Q: res_q_q <= scaled;
      OP_SQR_I:   pwr_q   <= prod[PwrW-1:0];
      OP_SQR_Q:   pwr_q   <= pwr_q + prod[PwrW-1:0];
      OP_ERR:     err_q   <= err_d;
      OP_PROD_LO: acc_q   <= prod_ext;
      OP_PROD_HI: acc_q   <= acc_q + (prod_ext <<< 17);
      default: ;
    endcase
  end

  assign out_i_o = res_i_q;
  assign out_q_o = res_q_q;

endmodule

[verif/iq_agc_asymmetric_tb.sv]
// Self-checking testbench for the iq_agc_asymmetric I/Q gain control block.
// Depends on iqagc_pkg and the iq_agc_asymmetric RTL. It predicts every output
// sample and checks it under random stream pressure and several register settings.

// Tracks gain, target power and rates, and holds the output samples still owed.
class agc_scoreboard;
  localparam longint GainCeil = (64'sd1 <<< iqagc_pkg::GainW) - 1;

  bit [iqagc_pkg::GainW-1:0] gain_q816  = iqagc_pkg::GAIN_RESET;
  bit [iqagc_pkg::PwrW-1:0]  target_pwr = iqagc_pkg::REF_RESET;
  bit [iqagc_pkg::RateW-1:0] slow_rate  = iqagc_pkg::SLOW_RESET;
  bit [iqagc_pkg::RateW-1:0] fast_rate  = iqagc_pkg::FAST_RESET;
  bit [31:0] owed_out[$];  // {out_q, out_i}
  int unsigned n_samples, n_results, n_errors;
  int unsigned n_clipped, n_zero_err, n_floor, n_ceiling;

  function void write_reg(logic [iqagc_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
    case (idx)
      iqagc_pkg::CFG_REF_POWER: target_pwr = data;
      iqagc_pkg::CFG_RATE_SLOW: slow_rate  = data[iqagc_pkg::RateW-1:0];
      iqagc_pkg::CFG_RATE_FAST: fast_rate  = data[iqagc_pkg::RateW-1:0];
      default: ;  // unused index, write dropped
    endcase
  endfunction

  // Q1.15 sample times Q8.16 gain, round half up, clip to 16 bits
  function bit [15:0] apply_gain(bit [15:0] smp);
    longint s;
    longint r;
    s = $signed(smp);
    r = (s * longint'(gain_q816) + 64'sd32768) >>> 16;
    if (r > 32767) begin
      r = 32767;
      n_clipped++;
    end else if (r < -32768) begin
      r = -32768;
      n_clipped++;
    end
    return r[15:0];
  endfunction

  function void note_sample(logic [31:0] tdata);
    bit [15:0] oi;
    bit [15:0] oq;
    longint vi;
    longint vq;
    longint err;
    longint prod;
    longint g;
    oi = apply_gain(tdata[15:0]);
    oq = apply_gain(tdata[31:16]);
    vi = $signed(oi);
    vq = $signed(oq);
    err = longint'(target_pwr) - (vi * vi + vq * vq);
    if (err == 0) n_zero_err++;
    // below target: slow rate; at or above: fast rate
    prod = err * longint'(err > 0 ? slow_rate : fast_rate);
    g = longint'(gain_q816) + ((prod + 64'sd536870912) >>> 30);
    if (g <= 0) begin
      g = 0;
      n_floor++;
    end else if (g >= GainCeil) begin
      g = GainCeil;
      n_ceiling++;
    end
    gain_q816 = g[iqagc_pkg::GainW-1:0];
    owed_out.push_back({oq, oi});
    n_samples++;
  endfunction

  // Counts a mismatch; every one is reported
  function bit note_error();
    n_errors++;
    return 1'b1;
  endfunction

  function void check_result(logic [31:0] tdata);
    bit [31:0] want;
    if (owed_out.size() == 0) begin
      if (note_error()) $display("%0t: result %h with none outstanding", $time, tdata);
      return;
    end
    want = owed_out.pop_front();
    n_results++;
    if (tdata[15:0] !== want[15:0] && note_error())
      $display("%0t: out_i expected %0d, got %0d", $time,
               $signed(want[15:0]), $signed(tdata[15:0]));
    if (tdata[31:16] !== want[31:16] && note_error())
      $display("%0t: out_q expected %0d, got %0d", $time,
               $signed(want[31:16]), $signed(tdata[31:16]));
  endfunction

  function int unsigned pending();
    return owed_out.size();
  endfunction
endclass

module iq_agc_asymmetric_tb;
  import iqagc_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;  // no register behind it

  typedef enum int unsigned {RX_OPEN, RX_LOOSE, RX_TIGHT, RX_PATTERN} rx_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [31:0]        s_axis_tdata_i;   // in_i[15:0], in_q[31:16]
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [31:0]        m_axis_tdata_o;   // out_i[15:0], out_q[31:16]
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [31:0]        cfg_data_i;

  agc_scoreboard sb;
  int unsigned   cycles;
  int unsigned   burst_left;
  int unsigned   n_settings;
  rx_mode_e      rx_mode;
  int unsigned   rx_left;
  bit [7:0]      rx_pattern = 8'b1001_0110;

  // {in_q, in_i}: full scale, sign extremes, unit steps, clip threshold at gain 50,
  // alternating bits, and a lone -1.0 on either rail, which lands exactly on
  // the 1.0 target (zero error, fast rate)
  logic [31:0] directed_pairs [16] = '{
    32'h0000_0000, 32'h7FFF_7FFF, 32'h8000_8000, 32'h8000_7FFF,
    32'h7FFF_8000, 32'hFFFF_0001, 32'h0001_FFFF, 32'h0000_8000,
    32'h8000_0000, 32'h0000_0290, 32'h0000_028F, 32'hFD71_0000,
    32'hAAAA_5555, 32'h5555_AAAA, 32'h0001_0001, 32'hFFFF_FFFF
  };

  iq_agc_asymmetric u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result check first, then the new item, so a same-edge pair stays in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
      if (s_axis_tvalid_i && s_axis_tready_o) sb.note_sample(s_axis_tdata_i);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: segments of always-ready, light and heavy random stalls,
  // and a rotating ready pattern
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
    case (rx_mode)
      RX_OPEN:  m_axis_tready_i <= 1'b1;
      RX_LOOSE: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      RX_TIGHT: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      default:  m_axis_tready_i <= rx_pattern[0];
    endcase
  end

  // Valid stays up inside a burst; a gap of random length ends each burst
  task automatic send_sample(input logic [15:0] si, input logic [15:0] sq);
    s_axis_tdata_i  <= {sq, si};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 20);
    end
  endtask

  // Hold off until every owed result is out and the sequencer has settled
  task automatic drain_stream();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (12) @(posedge clk_i);
  endtask

  // Writes all three registers back to back; rate writes carry junk above bit 15
  task automatic configure(input logic [31:0] target, input logic [15:0] slow,
                           input logic [15:0] fast, input bit poke_unused);
    logic [CfgIdxW-1:0] idx_list [4];
    logic [31:0]        val_list [4];
    int unsigned        n_writes;
    idx_list = '{CFG_REF_POWER, CFG_RATE_SLOW, CFG_RATE_FAST, CFG_UNUSED};
    val_list = '{target, {16'($urandom), slow}, {16'($urandom), fast}, $urandom};
    n_writes = poke_unused ? 4 : 3;
    for (int unsigned k = 0; k < n_writes; k++) begin
      cfg_index_i <= idx_list[k];
      cfg_data_i  <= val_list[k];
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(idx_list[k], val_list[k]);
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // Mostly samples within +/- 2^level, some full-range and rail values
  function automatic logic [15:0] draw_sample(input int unsigned level);
    int unsigned span;
    span = 1 << level;
    case ($urandom_range(0, 19))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1, 2:    return 16'($urandom);
      default: return 16'($urandom_range(0, 2 * span - 1) - span);
    endcase
  endfunction

  // Signal level steps every 32 items so the loop sees both settling and jumps
  task automatic stream_random(input int unsigned count);
    int unsigned level;
    level = 15;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 32 == 0) level = $urandom_range(0, 15);
      send_sample(draw_sample(level), draw_sample(level));
    end
  endtask

  initial begin
    logic [31:0] target;
    logic [15:0] slow;
    logic [15:0] fast;
    sb = new;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    burst_left = 0;
    n_settings = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: directed corners, then random traffic
    foreach (directed_pairs[k]) send_sample(directed_pairs[k][15:0], directed_pairs[k][31:16]);
    stream_random(140);
    drain_stream();

    // Zero target at full fast rate: gain collapses and pins at zero
    configure(32'h0000_0000, 16'hFFFF, 16'hFFFF, 1'b0);
    stream_random(190);
    drain_stream();

    // Max target at full slow rate: gain climbs from zero and pins at the top
    configure(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 1'b1);
    stream_random(190);
    drain_stream();

    // Both rates zero: gain frozen at full scale
    configure(REF_RESET, 16'h0000, 16'h0000, 1'b0);
    stream_random(190);
    drain_stream();

    // Target at the largest reachable power, smallest nonzero rates
    configure(32'h8000_0000, 16'h0001, 16'h0001, 1'b1);
    stream_random(190);
    drain_stream();

    repeat (5) begin
      target = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h8000_0000);
      slow   = 16'($urandom >> $urandom_range(0, 16));
      fast   = 16'($urandom >> $urandom_range(0, 16));
      configure(target, slow, fast, $urandom_range(0, 1));
      stream_random(190);
      drain_stream();
    end

    $display("Run covered %0d samples over %0d register settings,", sb.n_samples, n_settings);
    $display("%0d clipped outputs, %0d zero-error updates", sb.n_clipped, sb.n_zero_err);
    $display("Gain pinned at zero on %0d updates and at full scale on %0d; %0d results checked",
             sb.n_floor, sb.n_ceiling, sb.n_results);
    if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
